// ===== sv/pac_pkg.sv =====
// Package with widths, register map, reset values and shared types.
`timescale 1ns / 1ps
package pac_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MeasW   = 16;
  localparam int unsigned SpW     = 10;
  localparam int unsigned EnW     = 7;
  localparam int unsigned DigW    = 11;
  localparam int unsigned DrvW    = 12;
  localparam int unsigned IntW    = 20;
  localparam int unsigned DbW     = 8;
  localparam int unsigned NumW    = SpW + IntW;
  localparam int unsigned CntW    = $clog2(NumW + 1);
  localparam int unsigned AddrW   = 4;
  localparam int unsigned InDataW = 136;
  localparam int unsigned OutDataW = 48;

  localparam logic [AddrW-3:0] RegInterval  = 2'd0;
  localparam logic [AddrW-3:0] RegSpeed     = 2'd1;
  localparam logic [AddrW-3:0] RegThreshold = 2'd2;
  localparam logic [AddrW-3:0] RegDeadband  = 2'd3;

  localparam logic [IntW-1:0] IntervalRst  = 20'd10000;
  localparam logic [SpW-1:0]  SpeedRst     = 10'd128;
  localparam logic [SpW-1:0]  ThresholdRst = 10'd96;
  localparam logic [DbW-1:0]  DeadbandRst  = 8'd5;

  typedef struct packed {
    logic [IntW-1:0] interval;
    logic [SpW-1:0]  speed;
    logic [SpW-1:0]  threshold;
    logic [DbW-1:0]  deadband;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/pac_cfg.sv =====
// APB register file for pulse and cooling settings.
`timescale 1ns / 1ps
module pac_cfg import pac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[AddrW-1:2])
        RegInterval:  cfg_d.interval  = pwdata[IntW-1:0];
        RegSpeed:     cfg_d.speed     = pwdata[SpW-1:0];
        RegThreshold: cfg_d.threshold = pwdata[SpW-1:0];
        RegDeadband:  cfg_d.deadband  = pwdata[DbW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[AddrW-1:2])
      RegInterval:  prdata = {{(32-IntW){1'b0}}, cfg_q.interval};
      RegSpeed:     prdata = {{(32-SpW){1'b0}}, cfg_q.speed};
      RegThreshold: prdata = {{(32-SpW){1'b0}}, cfg_q.threshold};
      RegDeadband:  prdata = {{(32-DbW){1'b0}}, cfg_q.deadband};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval  <= IntervalRst;
      cfg_q.speed     <= SpeedRst;
      cfg_q.threshold <= ThresholdRst;
      cfg_q.deadband  <= DeadbandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/pac_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pac_div import pac_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [SpW-1:0]  divisor_i,
  output div_stat_t       stat_o,
  output logic [NumW-1:0] quotient_o
);

  logic [NumW-1:0] quo_q, quo_d;
  logic [SpW-1:0]  rem_q, rem_d;
  logic [SpW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [SpW:0]    trial;
  logic [SpW:0]    diff;
  logic            fits;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NumW-2:0], fits};
      rem_d = fits ? diff[SpW-1:0] : trial[SpW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== sv/process_actuator_controller_unit.sv =====
// Top level: tick sequencer, actuator logic and held output register.
// A new input is taken only when idle, after the last result enters the output register.
// The 30-step divider computes the pulse on-time.
// A full result may wait in the output register while the next input is taken.
// Reset (async, active low) loads register defaults and clears the held output and pulse state.
`timescale 1ns / 1ps
module process_actuator_controller_unit import pac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // time_ms, fluid_level, temperature, level_setpoint, filter_setpoint,
  // aeration_setpoint, feed_setpoint, temp_setpoint, enables, foam_active
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // direct_mode
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // valve_bits, filter_drive, feed_drive, aeration_drive
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StStart = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  cfg_t            cfg;
  div_stat_t       div_stat;
  logic [NumW-1:0] quotient;

  logic [1:0] state_q, state_d;
  logic [InDataW-1:0] in_q;
  logic               direct_q;

  logic            pmode_prev_q, pulse_on_q;
  logic [TimeW-1:0] pulse_start_q, pulse_end_q;
  logic [DigW-1:0] held_dig_q;
  logic [DrvW-1:0] held_filt_q, held_feed_q, held_aer_q;
  logic            out_vld_q;

  logic [TimeW-1:0] t;
  logic [MeasW-1:0] level, temp, level_sp, temp_sp;
  logic [SpW-1:0]   filter_sp, aer_sp, feed_sp;
  logic [EnW-1:0]   en;
  logic             foam;

  logic [DigW-1:0]  dig;
  logic [DrvW-1:0]  filt, aer, feed;
  logic             pmode, start_pulse, on1, stop_pulse, fin_go;
  logic [TimeW-1:0] dt, end1, next_start;
  logic signed [MeasW+1:0] temp_s, sp_lo, sp_hi;

  pac_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign t         = in_q[31:0];
  assign level     = in_q[47:32];
  assign temp      = in_q[63:48];
  assign level_sp  = in_q[79:64];
  assign filter_sp = in_q[89:80];
  assign aer_sp    = in_q[99:90];
  assign feed_sp   = in_q[109:100];
  assign temp_sp   = in_q[125:110];
  assign en        = in_q[132:126];
  assign foam      = in_q[133];

  pac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StStart),
    .dividend_i (NumW'(feed_sp * cfg.interval)),
    .divisor_i  (cfg.speed),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign fin_go = (state_q == StFin) && (!out_vld_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_axis_tvalid_i) state_d = StStart;
      StStart: state_d = StDiv;
      StDiv:   if (div_stat.done) state_d = StFin;
      StFin:   if (fin_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // tick computation
  assign next_start = pulse_start_q + {{(TimeW-IntW){1'b0}}, cfg.interval};
  assign dt         = (cfg.speed == '0) ? '1 : {{(TimeW-NumW){1'b0}}, quotient};
  assign pmode      = feed_sp < cfg.threshold;
  assign start_pulse = pmode && en[4] && !pulse_on_q && (t > next_start);
  assign on1        = start_pulse | pulse_on_q;
  assign end1       = start_pulse ? (t + dt) : pulse_end_q;
  assign stop_pulse = pmode && on1 && (t > end1);

  assign temp_s = $signed({2'b00, temp});
  assign sp_lo  = $signed({2'b00, temp_sp}) - $signed({{(MeasW-DbW+2){1'b0}}, cfg.deadband});
  assign sp_hi  = $signed({2'b00, temp_sp}) + $signed({{(MeasW-DbW+2){1'b0}}, cfg.deadband});

  always_comb begin
    dig  = '0;
    filt = '0;
    aer  = '0;
    feed = pmode_prev_q ? held_feed_q : '0;
    if (en[0] && level < level_sp) dig[4] = 1'b1;
    if (en[1]) begin
      filt = {filter_sp, 2'b00};
      if (en[2]) dig[8] = 1'b1;
      else       dig[9] = 1'b1;
    end
    if (en[3]) begin
      aer    = {aer_sp, 2'b00};
      dig[1] = (aer_sp != '0);
      dig[3] = 1'b1;
    end
    dig[10] = foam;
    if (pmode) begin
      if (start_pulse) feed = {cfg.speed, 2'b00};
      if (stop_pulse)  feed = '0;
    end else if (en[4]) begin
      feed = {feed_sp, 2'b00};
    end
    if (en[5]) begin
      dig[6] = temp_s < sp_lo;
      dig[5] = temp_s > sp_hi;
    end
    if (en[6]) begin
      dig[0] = 1'b1;
      dig[2] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      pmode_prev_q  <= 1'b0;
      pulse_on_q    <= 1'b0;
      pulse_start_q <= '0;
      pulse_end_q   <= '0;
      held_dig_q    <= '0;
      held_filt_q   <= '0;
      held_feed_q   <= '0;
      held_aer_q    <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_vld_q <= 1'b1;
        if (!direct_q) begin
          pmode_prev_q <= pmode;
          pulse_on_q   <= on1 & ~stop_pulse;
          if (start_pulse) begin
            pulse_start_q <= t;
            pulse_end_q   <= end1;
          end
          held_dig_q  <= dig;
          held_filt_q <= filt;
          held_feed_q <= feed;
          held_aer_q  <= aer;
        end
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q     <= s_axis_tdata_i;
      direct_q <= s_axis_tuser_i;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, held_aer_q, held_feed_q, held_filt_q, held_dig_q};

endmodule

// ===== sv/pac_checker.sv =====
// Port-level checker for the actuator controller, bound to the top level.
`timescale 1ns / 1ps
module pac_sva import pac_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                pready
);

  // one transaction in flight: no new input right after one is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while a tick is in progress");

  // a result only appears after the block was busy
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without preceding work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("config port stalled");

endmodule

bind process_actuator_controller_unit pac_sva u_pac_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .pready          (pready)
);
